// File: rtl/lpl_pkg.sv
`timescale 1ns / 1ps

package lpl_pkg;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_INVAL  = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    localparam logic [7:0] MAX_PFX_LEN = 8'd128;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  slot;
        logic [63:0] entry_hi;
        logic [63:0] entry_lo;
        logic [7:0]  entry_len;
        logic [63:0] query_hi;
        logic [63:0] query_lo;
        logic [7:0]  want_len;
    } lpl_req_t;

    typedef struct packed {
        logic       found;
        logic [3:0] hit_slot;
        logic [7:0] hit_len;
    } lpl_rsp_t;

    // Item as it travels down the chain, with the best match found so far.
    typedef struct packed {
        logic        valid;
        logic [1:0]  action;
        logic [3:0]  slot;
        logic [63:0] entry_hi;
        logic [63:0] entry_lo;
        logic [7:0]  entry_len;
        logic [63:0] query_hi;
        logic [63:0] query_lo;
        logic [7:0]  want_len;
        logic        have;
        logic [3:0]  best_slot;
        logic [7:0]  best_len;
    } lpl_tok_t;

endpackage

// File: rtl/lpl_cell.sv
`timescale 1ns / 1ps

module lpl_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  lpl_pkg::lpl_tok_t tok_in,
    output lpl_pkg::lpl_tok_t tok_out
);
    import lpl_pkg::*;

    logic [63:0]  hi_reg;
    logic [63:0]  lo_reg;
    logic [7:0]   len_reg;
    logic         valid_reg;
    logic         valid_next;
    lpl_tok_t     tok_reg;
    lpl_tok_t     tok_next;
    logic [127:0] mask;
    logic         matched;
    logic         take;
    logic         slot_hit;

    assign slot_hit = tok_in.valid && (32'(tok_in.slot) == IDX);

    always_comb
    begin
        mask    = ~({128{1'b1}} >> len_reg);
        matched = valid_reg &&
                  ((({hi_reg, lo_reg} ^ {tok_in.query_hi, tok_in.query_lo}) & mask) == '0);
        take = 1'b0;
        if (tok_in.action == ACT_LOOKUP && matched)
        begin
            if (tok_in.want_len != 8'd0)
                take = !tok_in.have && (len_reg == tok_in.want_len);
            else
                take = !tok_in.have || (len_reg > tok_in.best_len);
        end
        tok_next = tok_in;
        if (take)
        begin
            tok_next.have      = 1'b1;
            tok_next.best_slot = 4'(IDX);
            tok_next.best_len  = len_reg;
        end
        valid_next = valid_reg;
        if (adv && slot_hit && tok_in.action == ACT_WRITE)
            valid_next = 1'b1;
        else if (adv && slot_hit && tok_in.action == ACT_INVAL)
            valid_next = 1'b0;
    end

    // Entry contents: no reset, only read behind the valid bit.
    always_ff @(posedge clk)
    begin
        if (adv && slot_hit && tok_in.action == ACT_WRITE)
        begin
            hi_reg  <= tok_in.entry_hi;
            lo_reg  <= tok_in.entry_lo;
            len_reg <= tok_in.entry_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (adv)
                tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: rtl/ipv6_longest_prefix_lookup_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload    Handshake
// req      in         lpl_req_t  req_valid / req_ready
// rsp      out        lpl_rsp_t  rsp_valid / rsp_ready
//
// Each item walks a chain of TABLE_DEPTH entry cells, one cell per cycle, and
// the next item is accepted only once the result of the last is loaded into
// the result register. Reset clears all slot valid bits at once. A result
// that is not taken holds the chain; a new item is accepted while the result
// register is full.
module ipv6_longest_prefix_lookup_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  lpl_pkg::lpl_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output lpl_pkg::lpl_rsp_t rsp
);
    import lpl_pkg::*;

    lpl_tok_t                tok [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0]  tok_vld;
    logic                    busy_reg;
    logic                    busy_next;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    lpl_rsp_t                rsp_reg;
    logic                    adv;
    logic                    load;
    logic                    accept;

    assign req_ready = !busy_reg;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        tok[0].valid     = accept;
        tok[0].action    = req.action;
        tok[0].slot      = req.slot;
        tok[0].entry_hi  = req.entry_hi;
        tok[0].entry_lo  = req.entry_lo;
        tok[0].entry_len = (req.entry_len > MAX_PFX_LEN) ? MAX_PFX_LEN : req.entry_len;
        tok[0].query_hi  = req.query_hi;
        tok[0].query_lo  = req.query_lo;
        tok[0].want_len  = req.want_len;
        tok[0].have      = 1'b0;
        tok[0].best_slot = 4'd0;
        tok[0].best_len  = 8'd0;
    end

    // Hold the chain while a finished item waits on a full result register.
    assign adv  = !(tok[TABLE_DEPTH].valid && rsp_valid_reg && !rsp_ready);
    assign load = tok[TABLE_DEPTH].valid && adv;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        lpl_cell #(
            .IDX(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .tok_in (tok[i]),
            .tok_out(tok[i+1])
        );
        assign tok_vld[i] = tok[i+1].valid;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (load)
            busy_next = 1'b0;
        rsp_valid_next = rsp_valid_reg;
        if (load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg.found    <= tok[TABLE_DEPTH].have;
            rsp_reg.hit_slot <= tok[TABLE_DEPTH].best_slot;
            rsp_reg.hit_len  <= tok[TABLE_DEPTH].best_len;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one item in the cell chain");

    a_busy_tracks_chain: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (|tok_vld))
        else $error("busy flag disagrees with the cell chain");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req_ready && tok[1].valid)
        else $error("accepted item did not enter the chain");

endmodule

// File: bench/ipv6_longest_prefix_lookup_top_test.sv
`timescale 1ns / 1ps

module ipv6_longest_prefix_lookup_top_test;

    import lpl_pkg::*;

    localparam int               DEPTH       = 16;
    localparam int               RANDOM_ITEMS = 1800;
    localparam int               HOLD_AT     = 300;
    localparam int               HOLD_CYCLES = 400;
    localparam logic [1:0]       ACT_UNUSED  = 2'd3;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    lpl_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    lpl_rsp_t rsp;

    ipv6_longest_prefix_lookup_top #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Shadow of the prefix table as the block should hold it
    logic [127:0] tbl_addr [DEPTH];
    logic [7:0]   tbl_len [DEPTH];
    bit           tbl_valid [DEPTH];

    // What the stimulus generator believes is stored, used to aim lookups
    logic [127:0] gen_addr [DEPTH];
    int           gen_len [DEPTH];
    bit           gen_used [DEPTH];
    logic [127:0] bases [4];

    lpl_req_t feed_reqs [$];
    bit       feed_drain [$];
    bit       drain_next;
    lpl_rsp_t pending_answers [$];

    int items_total;
    int items_accepted;
    int answers_checked;
    int error_count;
    int gap_left;
    int stall_left;
    int hold_left;
    int n_write, n_inval, n_unused, n_lookup, n_hit, n_exact_hit;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #(20 * 400000);
        $display("ipv6_longest_prefix_lookup_top_test failed");
        $finish;
    end

    function automatic logic [127:0] lead_mask(input int n);
        if (n <= 0)
            return '0;
        if (n >= 128)
            return {128{1'b1}};
        return {128{1'b1}} << (128 - n);
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Keep the leading n bits of base, randomize the rest
    function automatic logic [127:0] keep_lead(input logic [127:0] base, input int n);
        logic [127:0] m;
        m = lead_mask(n);
        return (base & m) | (rand128() & ~m);
    endfunction

    // Apply one item to the shadow table and return the answer it should produce
    function automatic lpl_rsp_t lookup_answer(input lpl_req_t r);
        lpl_rsp_t ans;
        bit       done;
        ans = '0;
        done = 1'b0;
        case (r.action)
            ACT_WRITE:
            begin
                n_write++;
                tbl_addr[r.slot] = {r.entry_hi, r.entry_lo};
                tbl_len[r.slot] = (r.entry_len > MAX_PFX_LEN) ? MAX_PFX_LEN : r.entry_len;
                tbl_valid[r.slot] = 1'b1;
            end
            ACT_INVAL:
            begin
                n_inval++;
                tbl_valid[r.slot] = 1'b0;
            end
            ACT_LOOKUP:
            begin
                n_lookup++;
                for (int i = 0; i < DEPTH; i++) begin
                    if (!done && tbl_valid[i] &&
                        (((tbl_addr[i] ^ {r.query_hi, r.query_lo}) & lead_mask(tbl_len[i]))
                         == '0)) begin
                        if (r.want_len != 0) begin
                            if (tbl_len[i] == r.want_len) begin
                                ans = '{found: 1'b1, hit_slot: 4'(i), hit_len: tbl_len[i]};
                                done = 1'b1;
                            end
                        end else if (!ans.found || tbl_len[i] > ans.hit_len) begin
                            ans = '{found: 1'b1, hit_slot: 4'(i), hit_len: tbl_len[i]};
                        end
                    end
                end
                if (ans.found) begin
                    n_hit++;
                    if (r.want_len != 0)
                        n_exact_hit++;
                end
            end
            default:
                n_unused++;
        endcase
        return ans;
    endfunction

    // Idle cycles before the next item; some stretches run with no idling
    function automatic int draw_wait(input int count, input int period);
        if ((count / period) % 3 == 1)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic lpl_req_t random_req();
        lpl_req_t r;
        r.action    = 2'($urandom);
        r.slot      = 4'($urandom);
        r.entry_hi  = {$urandom, $urandom};
        r.entry_lo  = {$urandom, $urandom};
        r.entry_len = 8'($urandom);
        r.query_hi  = {$urandom, $urandom};
        r.query_lo  = {$urandom, $urandom};
        r.want_len  = 8'($urandom);
        return r;
    endfunction

    function automatic int pick_used();
        int list [$];
        for (int i = 0; i < DEPTH; i++)
            if (gen_used[i])
                list.push_back(i);
        if (list.size() == 0)
            return -1;
        return list[$urandom_range(0, list.size() - 1)];
    endfunction

    function automatic int rand_entry_len();
        int boundary_lens [7] = '{0, 1, 63, 64, 65, 127, 128};
        int p;
        p = $urandom_range(0, 99);
        if (p < 15)
            return boundary_lens[$urandom_range(0, 6)];
        if (p < 25)
            return $urandom_range(129, 255);
        return $urandom_range(0, 128);
    endfunction

    task automatic add_item(input lpl_req_t r);
        feed_reqs.push_back(r);
        feed_drain.push_back(drain_next);
        drain_next = 1'b0;
    endtask

    task automatic add_write(input int s, input logic [127:0] a, input int len);
        lpl_req_t r;
        r = random_req();
        r.action = ACT_WRITE;
        r.slot = 4'(s);
        {r.entry_hi, r.entry_lo} = a;
        r.entry_len = 8'(len);
        gen_addr[s] = a;
        gen_len[s] = (len > 128) ? 128 : len;
        gen_used[s] = 1'b1;
        add_item(r);
    endtask

    task automatic add_inval(input int s);
        lpl_req_t r;
        r = random_req();
        r.action = ACT_INVAL;
        r.slot = 4'(s);
        gen_used[s] = 1'b0;
        add_item(r);
    endtask

    task automatic add_lookup(input logic [127:0] q, input int want);
        lpl_req_t r;
        r = random_req();
        r.action = ACT_LOOKUP;
        {r.query_hi, r.query_lo} = q;
        r.want_len = 8'(want);
        add_item(r);
    endtask

    task automatic add_random_item();
        lpl_req_t     r;
        logic [127:0] q;
        int           p;
        int           s;
        int           k;
        int           w;
        p = $urandom_range(0, 99);
        if (p < 25) begin
            if ($urandom_range(0, 4) == 0)
                q = rand128();
            else
                q = keep_lead(bases[$urandom_range(0, 3)], $urandom_range(0, 128));
            add_write($urandom_range(0, DEPTH - 1), q, rand_entry_len());
        end else if (p < 32) begin
            add_inval($urandom_range(0, DEPTH - 1));
        end else if (p < 35) begin
            r = random_req();
            r.action = ACT_UNUSED;
            add_item(r);
        end else begin
            p = $urandom_range(0, 99);
            s = pick_used();
            if (p < 70 && s >= 0) begin
                q = keep_lead(gen_addr[s], gen_len[s]);
                // break the match inside the prefix now and then
                if ($urandom_range(0, 4) == 0 && gen_len[s] > 0) begin
                    k = $urandom_range(0, gen_len[s] - 1);
                    q[127 - k] = ~q[127 - k];
                end
            end else if (p < 90) begin
                q = keep_lead(bases[$urandom_range(0, 3)], $urandom_range(0, 128));
            end else begin
                q = rand128();
            end
            p = $urandom_range(0, 99);
            s = pick_used();
            if (p < 50)
                w = 0;
            else if (p < 80 && s >= 0)
                w = gen_len[s];
            else if (p < 90)
                w = $urandom_range(0, 128);
            else
                w = $urandom_range(129, 255);
            add_lookup(q, w);
        end
    endtask

    task automatic check_answer(input lpl_rsp_t got);
        lpl_rsp_t want;
        if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result found=%0d hit_slot=%0d hit_len=%0d",
                     $time, got.found, got.hit_slot, got.hit_len);
            error_count++;
        end else begin
            want = pending_answers.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found mismatch, expected %0d, got %0d",
                         $time, want.found, got.found);
                error_count++;
            end
            if (got.hit_slot !== want.hit_slot) begin
                $display("%0t: hit_slot mismatch, expected %0d, got %0d",
                         $time, want.hit_slot, got.hit_slot);
                error_count++;
            end
            if (got.hit_len !== want.hit_len) begin
                $display("%0t: hit_len mismatch, expected %0d, got %0d",
                         $time, want.hit_len, got.hit_len);
                error_count++;
            end
        end
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            req <= '0;
            gap_left = 0;
        end else begin
            if (req_valid && req_ready) begin
                pending_answers.push_back(lookup_answer(req));
                items_accepted++;
                gap_left = draw_wait(items_accepted, 200);
            end
            if (req_valid && !req_ready) begin
                // hold the item until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                req_valid <= 1'b0;
            end else if (feed_reqs.size() > 0 &&
                         (!feed_drain[0] || pending_answers.size() == 0)) begin
                req <= feed_reqs.pop_front();
                void'(feed_drain.pop_front());
                req_valid <= 1'b1;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                check_answer(rsp);
                answers_checked++;
                stall_left = draw_wait(answers_checked, 170);
                if (answers_checked == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [127:0] ones;
        ones = {128{1'b1}};
        drain_next = 1'b0;
        for (int i = 0; i < 4; i++)
            bases[i] = rand128();

        // empty table
        add_lookup(rand128(), 0);
        // nested prefixes of the all-ones address, a catch-all and an over-long all-zeros entry
        add_write(0, rand128(), 0);
        add_write(1, ones, 128);
        add_write(2, ones, 64);
        add_write(3, ones, 65);
        add_write(4, ones, 63);
        add_write(15, ones, 1);
        add_write(5, '0, 200);
        add_write(6, ones, 64);
        add_lookup(ones, 0);
        add_lookup(ones, 64);
        add_lookup(ones ^ 128'd1, 0);
        add_lookup(ones ^ (128'd1 << 63), 0);
        add_lookup('0, 128);
        add_lookup('0, 0);
        add_lookup(ones, 129);
        add_lookup(ones, 255);
        add_lookup(ones >> 1, 0);
        add_inval(1);
        add_lookup(ones, 0);
        add_write(7, ones, 255);
        add_lookup(ones, 128);
        add_inval(0);
        add_lookup(ones >> 1, 0);
        begin
            lpl_req_t r;
            r = random_req();
            r.action = ACT_UNUSED;
            add_item(r);
        end

        drain_next = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2)
                drain_next = 1'b1;
            add_random_item();
        end
        items_total = feed_reqs.size();

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < items_total || answers_checked < items_accepted)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d items: %0d writes, %0d invalidates, %0d unused codes, %0d lookups",
                 items_accepted, n_write, n_inval, n_unused, n_lookup);
        $display("Lookups found %0d (%0d by exact length), %0d missed; one %0d-cycle hold-off",
                 n_hit, n_exact_hit, n_lookup - n_hit, HOLD_CYCLES);
        if (error_count == 0)
            $display("ipv6_longest_prefix_lookup_top_test passed");
        else
            $display("ipv6_longest_prefix_lookup_top_test failed");
        $finish;
    end

endmodule
